### src/qsld_pkg.sv
// qsld_pkg: shared types, constants and tables for the QOA slice LMS decoder.
// No dependencies; compiled first.

package qsld_pkg;

    localparam int TAPS      = 4;
    localparam int SLICE_LEN = 20;
    localparam int CNT_W     = 5;
    localparam int SAMPLE_W  = 16;
    localparam int RES_W     = 16;
    localparam int CODE_W    = 3;
    localparam int WORD_W    = 64;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 34;
    localparam int PRED_W    = 21;
    localparam int SUM_W     = 22;
    localparam int PRED_SHIFT = 13;

    typedef enum logic [1:0] {
        OP_LOAD_HIST = 2'd0,
        OP_LOAD_WGT  = 2'd1,
        OP_DECODE    = 2'd2
    } qsld_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ACC,
        ST_WB
    } qsld_state_t;

    typedef struct packed {
        logic take;
        logic load_work;
        logic mul;
        logic step;
        logic last;
        logic write_back;
    } qsld_cmd_t;

    typedef struct packed {
        logic decode_ok;
        logic out_free;
    } qsld_status_t;

    // round((s+1)^2.75)
    function automatic logic [11:0] scale_lut(input logic [3:0] idx);
        logic [11:0] v;
        begin
            case (idx)
                4'd0:    v = 12'd1;
                4'd1:    v = 12'd7;
                4'd2:    v = 12'd21;
                4'd3:    v = 12'd45;
                4'd4:    v = 12'd84;
                4'd5:    v = 12'd138;
                4'd6:    v = 12'd211;
                4'd7:    v = 12'd304;
                4'd8:    v = 12'd421;
                4'd9:    v = 12'd562;
                4'd10:   v = 12'd731;
                4'd11:   v = 12'd928;
                4'd12:   v = 12'd1157;
                4'd13:   v = 12'd1419;
                4'd14:   v = 12'd1715;
                default: v = 12'd2048;
            endcase
            return v;
        end
    endfunction

    // dequant magnitude in quarter units; odd codes are negative
    function automatic logic [4:0] dq_mag(input logic [1:0] sel);
        logic [4:0] v;
        begin
            case (sel)
                2'd0:    v = 5'd3;
                2'd1:    v = 5'd10;
                2'd2:    v = 5'd18;
                default: v = 5'd28;
            endcase
            return v;
        end
    endfunction

    // scale * dequant, rounded half away from zero
    function automatic logic signed [RES_W-1:0] residual_calc(input logic [3:0] sidx,
                                                             input logic [CODE_W-1:0] code);
        logic [16:0] prod;
        logic [16:0] rnd;
        logic signed [RES_W-1:0] mag;
        begin
            prod = 17'(scale_lut(sidx)) * 17'(dq_mag(code[2:1]));
            rnd  = (prod + 17'd2) >> 2;
            mag  = RES_W'(rnd);
            return code[0] ? -mag : mag;
        end
    endfunction

endpackage

### src/qsld_in_if.sv
// qsld_in_if: input word channel (opcode, channel, data word) with valid/ready.
// Depends on nothing.

interface qsld_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  channel;
    logic [63:0] data_word;

    modport source (output valid, output opcode, output channel, output data_word,
                    input ready);
    modport sink   (input valid, input opcode, input channel, input data_word,
                    output ready);
endinterface

### src/qsld_out_if.sv
// qsld_out_if: output sample channel (sample, channel_out, last) with valid/ready.
// Depends on nothing.

interface qsld_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [2:0]         channel_out;
    logic               last;

    modport source (output valid, output sample, output channel_out, output last,
                    input ready);
    modport sink   (input valid, input sample, input channel_out, input last,
                    output ready);
endinterface

### src/qsld_ctrl.sv
// qsld_ctrl: sequencer FSM for load and slice decode words.
// Depends on qsld_pkg.

module qsld_ctrl
    import qsld_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  qsld_status_t status,
    output qsld_cmd_t    cmd
);

    qsld_state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             is_last;

    assign is_last = (cnt_reg == CNT_W'(SLICE_LEN - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.decode_ok)
                begin
                    state_next = ST_FETCH;
                end
                cnt_next = '0;
            end
            ST_FETCH: state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (status.out_free)
                begin
                    if (is_last)
                    begin
                        state_next = ST_WB;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_WB:    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            ST_FETCH: cmd.load_work = 1'b1;
            ST_MUL:   cmd.mul = 1'b1;
            ST_ACC:
            begin
                cmd.step = status.out_free;
                cmd.last = is_last;
            end
            ST_WB:    cmd.write_back = 1'b1;
            default:  cmd = '0;
        endcase
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !in_ready)
        else $error("input ready while a slice is in flight");

    a_start_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && status.decode_ok) |=> state_reg == ST_FETCH)
        else $error("decode word accepted without fetch");

    a_wb_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_back |-> $past(cmd.step && cmd.last))
        else $error("write-back without a last sample");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(SLICE_LEN))
        else $error("sample counter out of range");

endmodule

### src/qsld_dpath.sv
// qsld_dpath: predictor state stores, LMS multiply/accumulate, update and output register.
// Depends on qsld_pkg; driven by qsld_ctrl commands.

module qsld_dpath
    import qsld_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [1:0]                 opcode,
    input  logic [2:0]                 channel,
    input  logic [WORD_W-1:0]          data_word,
    input  qsld_cmd_t                  cmd,
    output qsld_status_t               status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [2:0]                 channel_out,
    output logic                       last
);

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic [WORD_W-1:0]       hist_mem [MAX_CHANNELS];
    logic [WORD_W-1:0]       wgt_mem  [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] hist_vld_reg;
    logic [MAX_CHANNELS-1:0] wgt_vld_reg;

    logic [WORD_W-1:0] hist_rd_reg, wgt_rd_reg;
    logic              hist_rd_vld_reg, wgt_rd_vld_reg;

    logic [CH_W-1:0]   in_idx;
    logic              in_range;
    logic [CH_W-1:0]   idx_reg;
    logic [2:0]        ch_reg;
    logic [3:0]        sidx_reg;
    logic [59:0]       codes_reg;

    logic signed [SAMPLE_W-1:0] hist_reg [TAPS];
    logic signed [SAMPLE_W-1:0] wgt_reg  [TAPS];
    logic signed [PROD_W-1:0]   prod_reg [TAPS];
    logic signed [RES_W-1:0]    res_reg;

    logic signed [ACC_W-1:0]    acc;
    logic signed [PRED_W-1:0]   pred;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] clamped;
    logic signed [SAMPLE_W-1:0] delta;
    logic [WORD_W-1:0]          hist_pack, wgt_pack;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [2:0]                 chan_out_reg;
    logic                       last_reg;

    assign in_idx   = CH_W'({{CH_W{1'b0}}, channel});
    assign in_range = (32'(channel) < 32'(MAX_CHANNELS));

    assign status.decode_ok = in_range && (opcode == OP_DECODE);
    assign status.out_free  = !out_valid_reg || out_ready;

    // state stores
    always_ff @(posedge clk)
    begin
        if (cmd.take && in_range && opcode == OP_LOAD_HIST)
        begin
            hist_mem[in_idx] <= data_word;
        end
        else if (cmd.write_back)
        begin
            hist_mem[idx_reg] <= hist_pack;
        end
        if (cmd.take && in_range && opcode == OP_LOAD_WGT)
        begin
            wgt_mem[in_idx] <= data_word;
        end
        else if (cmd.write_back)
        begin
            wgt_mem[idx_reg] <= wgt_pack;
        end
        if (cmd.take)
        begin
            hist_rd_reg <= hist_mem[in_idx];
            wgt_rd_reg  <= wgt_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg    <= '0;
            wgt_vld_reg     <= '0;
            hist_rd_vld_reg <= 1'b0;
            wgt_rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take && in_range && opcode == OP_LOAD_HIST)
            begin
                hist_vld_reg[in_idx] <= 1'b1;
            end
            if (cmd.take && in_range && opcode == OP_LOAD_WGT)
            begin
                wgt_vld_reg[in_idx] <= 1'b1;
            end
            if (cmd.write_back)
            begin
                hist_vld_reg[idx_reg] <= 1'b1;
                wgt_vld_reg[idx_reg]  <= 1'b1;
            end
            if (cmd.take)
            begin
                hist_rd_vld_reg <= hist_vld_reg[in_idx];
                wgt_rd_vld_reg  <= wgt_vld_reg[in_idx];
            end
        end
    end

    // slice word latch
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            idx_reg   <= in_idx;
            ch_reg    <= channel;
            sidx_reg  <= data_word[63:60];
            codes_reg <= data_word[59:0];
        end
        else if (cmd.step)
        begin
            codes_reg <= {codes_reg[56:0], 3'b000};
        end
    end

    // prediction and update
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            acc = acc + ACC_W'(prod_reg[i]);
        end
        pred  = PRED_W'(acc >>> PRED_SHIFT);
        sum   = SUM_W'(res_reg) + SUM_W'(pred);
        if (sum > 22'sd32767)
        begin
            clamped = 16'sh7FFF;
        end
        else if (sum < -22'sd32768)
        begin
            clamped = 16'sh8000;
        end
        else
        begin
            clamped = SAMPLE_W'(sum);
        end
        delta = res_reg >>> 4;
    end

    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            hist_pack[WORD_W-1-SAMPLE_W*i -: SAMPLE_W] = hist_reg[i];
            wgt_pack[WORD_W-1-SAMPLE_W*i -: SAMPLE_W]  = wgt_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                hist_reg[i] <= hist_rd_vld_reg ? hist_rd_reg[WORD_W-1-SAMPLE_W*i -: SAMPLE_W]
                                               : '0;
                wgt_reg[i]  <= wgt_rd_vld_reg ? wgt_rd_reg[WORD_W-1-SAMPLE_W*i -: SAMPLE_W]
                                              : '0;
            end
        end
        else if (cmd.step)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                wgt_reg[i] <= hist_reg[i][SAMPLE_W-1] ? wgt_reg[i] - delta : wgt_reg[i] + delta;
            end
            for (int i = 0; i < TAPS - 1; i++)
            begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[TAPS-1] <= clamped;
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                prod_reg[i] <= PROD_W'(hist_reg[i]) * PROD_W'(wgt_reg[i]);
            end
            res_reg <= residual_calc(sidx_reg, codes_reg[59:57]);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            sample_reg   <= clamped;
            chan_out_reg <= ch_reg;
            last_reg     <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign channel_out = chan_out_reg;
    assign last        = last_reg;

endmodule

### src/qoa_slice_lms_decoder_top.sv
// qoa_slice_lms_decoder_top: QOA slice decoder with per-channel four-tap LMS predictor.
// Depends on qsld_pkg, qsld_in_if, qsld_out_if, qsld_ctrl, qsld_dpath.
//
//  port        dir   word contents
//  slice_in    in    opcode, channel, data_word (load history / load weights / slice)
//  sample_out  out   sample, channel_out, last (twenty words per slice)
//
// Load words are taken in the accept step. A slice goes through accept, state fetch,
// then per sample a four-tap multiply step and an accumulate/clamp/update step,
// then a state write-back step.
// Each sample waits in the ACC step until the output register is free.
// Reset clears the row valid bits, so every channel reads zero history and weights.

module qoa_slice_lms_decoder_top
    import qsld_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    qsld_in_if.sink    slice_in,
    qsld_out_if.source sample_out
);

    qsld_cmd_t    cmd;
    qsld_status_t status;

    qsld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (slice_in.valid),
        .in_ready (slice_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    qsld_dpath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .opcode      (slice_in.opcode),
        .channel     (slice_in.channel),
        .data_word   (slice_in.data_word),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (sample_out.valid),
        .out_ready   (sample_out.ready),
        .sample      (sample_out.sample),
        .channel_out (sample_out.channel_out),
        .last        (sample_out.last)
    );

endmodule

### tb/qoa_slice_lms_decoder_top_test.sv
// Self-checking testbench for qoa_slice_lms_decoder_top: history/weight loads and slice decodes
// with random valid/ready idling, checked word by word against an in-bench LMS predictor.
// Depends on qsld_pkg, qsld_in_if, qsld_out_if and the decoder RTL.

module qoa_slice_lms_decoder_top_test;
    import qsld_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_CH        = 8;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         N_ITEMS     = 170;
    localparam int         HOLD_CYCLES = 400;
    localparam int         IDLE_LIMIT  = 3000;
    localparam int         MAX_REPORTS = 10;

    typedef struct {
        logic signed [15:0] sample;
        logic [2:0]         channel;
        logic               last;
    } pcm_word_t;

    class qoa_lms_predictor;
        logic signed [15:0] hist[N_CH*4];
        logic signed [15:0] wgt[N_CH*4];
        pcm_word_t          pending[$];
        int                 errors;
        int                 step_size[16] = '{1, 7, 21, 45, 84, 138, 211, 304,
                                              421, 562, 731, 928, 1157, 1419, 1715, 2048};
        int                 qmag[4] = '{3, 10, 18, 28};

        function new();
            foreach (hist[i])
            begin
                hist[i] = '0;
                wgt[i]  = '0;
            end
            errors = 0;
        endfunction

        function void take_word(logic [1:0] op, logic [2:0] ch, logic [63:0] w);
            int          b;
            int          scale;
            int          mag;
            int          r;
            int          s;
            int          delta;
            longint      acc;
            longint      pred;
            logic [2:0]  code;
            pcm_word_t   e;
            b = int'(ch) * 4;
            if (int'(ch) >= N_CH)
                return;
            case (op)
                OP_LOAD_HIST:
                    for (int i = 0; i < 4; i++)
                        hist[b+i] = w[63-16*i -: 16];
                OP_LOAD_WGT:
                    for (int i = 0; i < 4; i++)
                        wgt[b+i] = w[63-16*i -: 16];
                OP_DECODE:
                begin
                    scale = step_size[w[63:60]];
                    for (int n = 0; n < 20; n++)
                    begin
                        code = w[59-3*n -: 3];
                        mag  = (scale * qmag[code[2:1]] + 2) >>> 2;
                        r    = code[0] ? -mag : mag;
                        acc  = 0;
                        for (int i = 0; i < 4; i++)
                            acc += longint'(hist[b+i]) * longint'(wgt[b+i]);
                        pred = acc >>> 13;
                        s    = r + int'(pred);
                        if (s > 32767)
                            s = 32767;
                        else if (s < -32768)
                            s = -32768;
                        delta = r >>> 4;
                        for (int i = 0; i < 4; i++)
                        begin
                            if (hist[b+i] < 0)
                                wgt[b+i] = 16'(int'(wgt[b+i]) - delta);
                            else
                                wgt[b+i] = 16'(int'(wgt[b+i]) + delta);
                        end
                        for (int i = 0; i < 3; i++)
                            hist[b+i] = hist[b+i+1];
                        hist[b+3] = 16'(s);
                        e.sample  = 16'(s);
                        e.channel = ch;
                        e.last    = (n == 19);
                        pending.insert(pending.size(), e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic signed [15:0] s, logic [2:0] ch, logic lst);
            pcm_word_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected word: sample %0d ch %0d last %0b", s, ch, lst);
            end
            else
            begin
                e = pending.pop_front();
                if (e.sample !== s || e.channel !== ch || e.last !== lst)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: expected %0d/ch%0d/last%0b, got %0d/ch%0d/last%0b",
                                 e.sample, e.channel, e.last, s, ch, lst);
                end
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    qsld_in_if  slice_in();
    qsld_out_if sample_out();

    qoa_slice_lms_decoder_top #(.MAX_CHANNELS(N_CH)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .slice_in   (slice_in),
        .sample_out (sample_out)
    );

    qoa_lms_predictor lms = new();

    int item_count = 0;
    bit tx_eager   = 0;
    bit rx_eager   = 0;
    bit hold_req   = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic push_word(input logic [1:0] op, input logic [2:0] ch,
                             input logic [63:0] data);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            slice_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        slice_in.valid     <= 1'b1;
        slice_in.opcode    <= op;
        slice_in.channel   <= ch;
        slice_in.data_word <= data;
        do @(posedge clk); while (!slice_in.ready);
        lms.take_word(op, ch, data);
        if (op != OP_UNUSED)
            item_count++;
    endtask

    task automatic drain();
        slice_in.valid <= 1'b0;
        do @(posedge clk); while (lms.outstanding() != 0);
    endtask

    function automatic logic [15:0] rand_elem();
        int v;
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            1, 2:    return 16'($urandom);
            default:
            begin
                v = int'($urandom_range(0, 8191)) - 4096;
                return 16'(v);
            end
        endcase
    endfunction

    function automatic logic [63:0] rand_state();
        return {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    endfunction

    function automatic logic [63:0] rand_slice();
        return {$urandom, $urandom};
    endfunction

    // output side: random ready gaps, eager stretches, one long hold-off on request
    initial
    begin
        int gap;
        sample_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                gap      = HOLD_CYCLES;
                hold_req = 0;
            end
            else if (rx_eager)
                gap = 0;
            else
                gap = $urandom_range(0, 19);
            if (gap > 0)
            begin
                sample_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            sample_out.ready <= 1'b1;
            do @(posedge clk);
            while (!(sample_out.valid && sample_out.ready) && !hold_req);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sample_out.valid && sample_out.ready)
            lms.check_sample(sample_out.sample, sample_out.channel_out, sample_out.last);
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((slice_in.valid && slice_in.ready) || (sample_out.valid && sample_out.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [2:0] ch;
        int         pick;
        int         seq_no;
        bit         hold_done;
        bit         pause_done;

        seq_no     = 0;
        hold_done  = 0;
        pause_done = 0;

        rst_n              <= 1'b0;
        slice_in.valid     <= 1'b0;
        slice_in.opcode    <= OP_LOAD_HIST;
        slice_in.channel   <= '0;
        slice_in.data_word <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero state, extremes, all codes, saturation, unused opcode
        push_word(OP_DECODE, 3'd0, 64'h0);
        push_word(OP_DECODE, 3'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(OP_DECODE, 3'd0, {4'd9, 60'o01234567012345670123});
        push_word(OP_DECODE, 3'd0, {4'd4, 60'o76543210765432107654});
        push_word(OP_LOAD_HIST, 3'd2, {4{16'h7FFF}});
        push_word(OP_LOAD_WGT, 3'd2, {4{16'h7FFF}});
        push_word(OP_DECODE, 3'd2, {4'd15, 60'o0});
        push_word(OP_LOAD_HIST, 3'd3, {4{16'h8000}});
        push_word(OP_LOAD_WGT, 3'd3, {4{16'h7FFF}});
        push_word(OP_DECODE, 3'd3, {4'd15, 60'o11111111111111111111});
        push_word(OP_LOAD_HIST, 3'd5, {4{16'h8000}});
        push_word(OP_LOAD_WGT, 3'd5, {4{16'h8000}});
        push_word(OP_DECODE, 3'd5, {4'd0, 60'o01234567012345670123});
        push_word(OP_LOAD_HIST, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(OP_LOAD_WGT, 3'd7, 64'h0);
        push_word(OP_DECODE, 3'd7, rand_slice());
        push_word(OP_UNUSED, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF);
        push_word(OP_DECODE, 3'd4, {4'd15, 60'o0});
        push_word(OP_LOAD_HIST, 3'd6, {16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF});
        push_word(OP_LOAD_WGT, 3'd6, {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001});
        push_word(OP_DECODE, 3'd6, {4'd15, 60'o70707070707070707070});
        drain();

        while (item_count < N_ITEMS)
        begin
            if (seq_no % 6 == 0)
            begin
                tx_eager = ($urandom_range(0, 3) == 0);
                rx_eager = ($urandom_range(0, 3) == 0);
            end
            seq_no++;

            if (!hold_done && item_count >= 70)
            begin
                hold_done = 1;
                hold_req  = 1;
                tx_eager  = 1;
            end
            if (!pause_done && item_count >= 120)
            begin
                pause_done = 1;
                drain();
            end

            ch   = 3'($urandom_range(0, N_CH - 1));
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                push_word(OP_LOAD_HIST, ch, rand_state());
                push_word(OP_LOAD_WGT, ch, rand_state());
                repeat ($urandom_range(1, 3))
                    push_word(OP_DECODE, ch, rand_slice());
            end
            else if (pick < 85)
                push_word(OP_DECODE, ch, rand_slice());
            else if (pick < 95)
                push_word($urandom_range(0, 1) ? OP_LOAD_WGT : OP_LOAD_HIST, ch, rand_state());
            else
                push_word(OP_UNUSED, ch, rand_slice());
        end

        drain();
        repeat (60) @(posedge clk);

        if (lms.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
src/qsld_pkg.sv
src/qsld_in_if.sv
src/qsld_out_if.sv
src/qsld_ctrl.sv
src/qsld_dpath.sv
src/qoa_slice_lms_decoder_top.sv
tb/qoa_slice_lms_decoder_top_test.sv
